// ===== hw/rtl/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg - shared types and constants for the MPEG audio RTP packetiser
// Record kinds, register indexes, sequencer states and the request and
// status structs between the top level and the rate accounting unit.
// ----------------------------------------------------------------------------
package mrp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAYLOAD_SIZE      = 2'd0;
  localparam logic [1:0] CFG_FRAMES_PER_SECOND = 2'd1;
  localparam logic [1:0] CFG_SAMPLES_PER_FRAME = 2'd2;
  localparam logic [1:0] CFG_PAYLOAD_TYPE      = 2'd3;

  // Register reset values
  localparam logic [15:0] RST_PAYLOAD_SIZE      = 16'd1460;
  localparam logic [7:0]  RST_FRAMES_PER_SECOND = 8'd38;
  localparam logic [11:0] RST_SAMPLES_PER_FRAME = 12'd1152;
  localparam logic [6:0]  RST_PAYLOAD_TYPE      = 7'd14;

  // Record kinds
  localparam logic [2:0] KIND_HINT_CLOSE = 3'd0;
  localparam logic [2:0] KIND_PKT_START  = 3'd1;
  localparam logic [2:0] KIND_WHOLE      = 3'd2;
  localparam logic [2:0] KIND_FRAGMENT   = 3'd3;
  localparam logic [2:0] KIND_CONT_PKT   = 3'd4;

  localparam logic [15:0] ENTRY_HDR_BYTES  = 16'd4;
  localparam logic [15:0] MIN_FRAG_PAYLOAD = 16'd256;
  localparam logic [31:0] RTP_HDR_BYTES    = 32'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_COUNT,
    ST_BOOK,
    ST_RATE,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    EK_CLOSE,
    EK_START,
    EK_WHOLE,
    EK_FRAG,
    EK_CONT
  } emit_kind_t;

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_DIFF,
    RP_MUL,
    RP_SUM
  } rate_ph_t;

  typedef struct packed {
    logic        start;
    logic [11:0] len;
    logic [31:0] pkt_count;
    logic [7:0]  fps;
  } rate_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] peak;
  } rate_sts_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] pkt;
    logic [31:0] frm;
    logic [11:0] off;
    logic [11:0] len;
    logic [31:0] dur;
    logic [6:0]  pt;
    logic [31:0] peak;
    logic        last;
  } rec_t;

endpackage

// ===== hw/rtl/mrp_rate_acct.sv =====
// ----------------------------------------------------------------------------
// mrp_rate_acct - per second byte rate accounting
// Adds frame bytes, and at the end of each period of frames folds in 12
// header bytes per packet and keeps the running peak.
// ----------------------------------------------------------------------------
module mrp_rate_acct (
  input  logic               clk,
  input  logic               rst_n,
  input  mrp_pkg::rate_req_t req,
  output mrp_pkg::rate_sts_t sts
);

  mrp_pkg::rate_ph_t ph_r, ph_nxt;

  logic [7:0]  fis_r;       // frame in second
  logic [31:0] bts_r;       // bytes this second
  logic [31:0] fpos_r;      // first packet of second
  logic [31:0] peak_r;
  logic        end_r;       // period ends with this frame
  logic [31:0] pcl_r;
  logic [31:0] diff_r;
  logic [31:0] hdr_r;
  logic [7:0]  fps_eff;
  logic [31:0] total;

  assign fps_eff = (req.fps == 8'd0) ? 8'd1 : req.fps;
  assign total   = hdr_r + bts_r;

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      mrp_pkg::RP_IDLE: if (req.start) ph_nxt = mrp_pkg::RP_DIFF;
      mrp_pkg::RP_DIFF: ph_nxt = mrp_pkg::RP_MUL;
      mrp_pkg::RP_MUL:  ph_nxt = mrp_pkg::RP_SUM;
      mrp_pkg::RP_SUM:  ph_nxt = mrp_pkg::RP_IDLE;
      default:          ph_nxt = mrp_pkg::RP_IDLE;
    endcase
  end

  always_comb begin
    sts.done = (ph_r == mrp_pkg::RP_SUM);
    sts.peak = peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= mrp_pkg::RP_IDLE;
      fis_r  <= 8'd1;
      bts_r  <= 32'd0;
      fpos_r <= 32'd1;
      peak_r <= 32'd0;
    end else begin
      ph_r <= ph_nxt;
      case (ph_r)
        mrp_pkg::RP_IDLE: begin
          if (req.start) begin
            bts_r <= bts_r + 32'(req.len);
            end_r <= (fis_r >= fps_eff);
            pcl_r <= req.pkt_count;
          end
        end
        mrp_pkg::RP_DIFF: diff_r <= pcl_r - fpos_r;
        mrp_pkg::RP_MUL:  hdr_r  <= diff_r * mrp_pkg::RTP_HDR_BYTES;
        mrp_pkg::RP_SUM: begin
          if (end_r) begin
            if (total > peak_r) peak_r <= total;
            bts_r  <= 32'd0;
            fpos_r <= pcl_r;
            fis_r  <= 8'd1;
          end else begin
            fis_r <= fis_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mpeg_audio_rtp_packetizer.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_rtp_packetizer - RTP packing planner for MPEG audio frames
// Turns each frame length into the hint, packet and data entry records of
// its RTP packing, and tracks the peak byte rate per second.
// ----------------------------------------------------------------------------
// One request is one frame length. The block stalls its input while it works
// on a frame: it first decides whether the open hint must close, then steps
// a single subtract and compare unit once per fragment (one step for a frame
// that fits whole, up to 17 for a long frame in small packets) to count
// continuation packets, books the hint state and passes the frame through the
// difference, multiply and sum steps of the rate accounting unit. Only then,
// since every record carries the peak rate after this frame, are the records
// issued, one per cycle while the result side does not stall. The last record
// sits in the output register while the next request is already taken.
// ----------------------------------------------------------------------------
module mpeg_audio_rtp_packetizer #(
  parameter int unsigned MAX_FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // frame requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_frame_length,
  // record requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_record_kind,
  output logic [31:0] out_packet_number,
  output logic [31:0] out_frame_number,
  output logic [11:0] out_data_offset,
  output logic [11:0] out_data_length,
  output logic [31:0] out_hint_duration,
  output logic [6:0]  out_payload_type,
  output logic [31:0] out_peak_bytes_per_second,
  output logic        out_last
);

  // Frame lengths saturate at one below the frame size limit, and at most at 4095.
  localparam int unsigned LEN_CAP = (MAX_FRAME_BYTES - 1 > 4095) ? 4095 : MAX_FRAME_BYTES - 1;
  localparam logic [11:0] LEN_MAX = 12'(LEN_CAP);

  // configuration registers
  logic [15:0] psz_r;
  logic [7:0]  fps_r;
  logic [11:0] spf_r;
  logic [6:0]  pt_r;

  // packing state
  logic [31:0] pc_r;        // number for the next new packet
  logic [16:0] bih_r;       // bytes in open hint
  logic [15:0] fih_r;       // frames in open hint
  logic [31:0] fcnt_r;      // frame counter

  // per frame work registers
  mrp_pkg::state_t     state_r, state_nxt;
  mrp_pkg::emit_kind_t ek_r;
  logic [11:0] len_r;
  logic        close_r;     // hint closes before this frame
  logic        whole_r;     // frame goes in as one entry
  logic [15:0] chunk_r;     // fragment data size
  logic [31:0] dur_r;
  logic [31:0] fnum_r;
  logic [11:0] rem_r;       // bytes not yet placed (shared subtract unit)
  logic [11:0] off_r;
  logic [4:0]  ncont_r;     // continuation packets
  logic [31:0] epc_r;       // packet number while issuing

  // output register
  logic         out_valid_r;
  mrp_pkg::rec_t rec_r;

  mrp_pkg::rate_req_t rate_req;
  mrp_pkg::rate_sts_t rate_sts;

  // decision logic on the registered frame length
  logic [16:0] room;
  logic [16:0] room2;
  logic [16:0] need;
  logic        close_c;
  logic [15:0] psz_frag;
  logic [27:0] dur_prod;
  logic        rem_big;     // remaining bytes exceed one fragment
  logic [11:0] frag_len;
  logic [31:0] pc_final;
  logic [16:0] bih_base;
  logic        in_take;
  logic        slot_free;
  logic        load;
  mrp_pkg::rec_t rec_c;
  logic [31:0] epc_nxt;
  mrp_pkg::emit_kind_t ek_nxt;

  assign room     = ({1'b0, psz_r} > bih_r) ? ({1'b0, psz_r} - bih_r) : 17'd0;
  assign need     = 17'(len_r) + 17'(mrp_pkg::ENTRY_HDR_BYTES);
  assign close_c  = need > room;
  assign room2    = close_c ? {1'b0, psz_r} : room;
  assign psz_frag = (psz_r < mrp_pkg::MIN_FRAG_PAYLOAD) ? mrp_pkg::MIN_FRAG_PAYLOAD : psz_r;
  assign dur_prod = fih_r * spf_r;

  assign rem_big  = {4'd0, rem_r} > chunk_r;
  assign frag_len = rem_big ? chunk_r[11:0] : rem_r;

  assign pc_final = pc_r + 32'(close_r) + (whole_r ? 32'd0 : 32'(ncont_r));
  assign bih_base = close_r ? 17'd0 : bih_r;

  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrp_pkg::ST_IDLE:  if (in_valid) state_nxt = mrp_pkg::ST_PREP;
      mrp_pkg::ST_PREP:  state_nxt = mrp_pkg::ST_COUNT;
      mrp_pkg::ST_COUNT: if (whole_r || !rem_big) state_nxt = mrp_pkg::ST_BOOK;
      mrp_pkg::ST_BOOK:  state_nxt = mrp_pkg::ST_RATE;
      mrp_pkg::ST_RATE:  if (rate_sts.done) state_nxt = mrp_pkg::ST_EMIT;
      mrp_pkg::ST_EMIT:  if (slot_free && rec_c.last) state_nxt = mrp_pkg::ST_IDLE;
      default:           state_nxt = mrp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall           = (state_r != mrp_pkg::ST_IDLE);
    load               = (state_r == mrp_pkg::ST_EMIT) && slot_free;
    rate_req.start     = (state_r == mrp_pkg::ST_BOOK);
    rate_req.len       = len_r;
    rate_req.pkt_count = pc_final;
    rate_req.fps       = fps_r;
  end

  // record for the current emit step
  always_comb begin
    rec_c      = '0;
    rec_c.peak = rate_sts.peak;
    epc_nxt    = epc_r;
    ek_nxt     = ek_r;
    case (ek_r)
      mrp_pkg::EK_CLOSE: begin
        rec_c.kind = mrp_pkg::KIND_HINT_CLOSE;
        rec_c.dur  = dur_r;
        ek_nxt     = mrp_pkg::EK_START;
      end
      mrp_pkg::EK_START: begin
        rec_c.kind = mrp_pkg::KIND_PKT_START;
        rec_c.pkt  = epc_r;
        rec_c.pt   = pt_r;
        rec_c.last = !whole_r && (len_r == 12'd0);
        epc_nxt    = epc_r + 32'd1;
        ek_nxt     = whole_r ? mrp_pkg::EK_WHOLE : mrp_pkg::EK_FRAG;
      end
      mrp_pkg::EK_WHOLE: begin
        rec_c.kind = mrp_pkg::KIND_WHOLE;
        rec_c.frm  = fnum_r;
        rec_c.len  = len_r;
        rec_c.last = 1'b1;
      end
      mrp_pkg::EK_FRAG: begin
        rec_c.kind = mrp_pkg::KIND_FRAGMENT;
        rec_c.frm  = fnum_r;
        rec_c.off  = off_r;
        rec_c.len  = frag_len;
        rec_c.last = !rem_big;
        ek_nxt     = mrp_pkg::EK_CONT;
      end
      mrp_pkg::EK_CONT: begin
        rec_c.kind = mrp_pkg::KIND_CONT_PKT;
        rec_c.pkt  = epc_r;
        rec_c.pt   = pt_r;
        epc_nxt    = epc_r + 32'd1;
        ek_nxt     = mrp_pkg::EK_FRAG;
      end
      default: ;
    endcase
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psz_r <= mrp_pkg::RST_PAYLOAD_SIZE;
      fps_r <= mrp_pkg::RST_FRAMES_PER_SECOND;
      spf_r <= mrp_pkg::RST_SAMPLES_PER_FRAME;
      pt_r  <= mrp_pkg::RST_PAYLOAD_TYPE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        mrp_pkg::CFG_PAYLOAD_SIZE:      psz_r <= cfg_data;
        mrp_pkg::CFG_FRAMES_PER_SECOND: fps_r <= cfg_data[7:0];
        mrp_pkg::CFG_SAMPLES_PER_FRAME: spf_r <= cfg_data[11:0];
        mrp_pkg::CFG_PAYLOAD_TYPE:      pt_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrp_pkg::ST_IDLE;
      pc_r    <= 32'd1;
      bih_r   <= 17'd0;
      fih_r   <= 16'd0;
      fcnt_r  <= 32'd1;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        mrp_pkg::ST_BOOK: begin
          pc_r   <= pc_final;
          bih_r  <= whole_r ? (bih_base + 17'(len_r) + 17'(mrp_pkg::ENTRY_HDR_BYTES))
                            : {1'b0, psz_r};
          fih_r  <= (close_r ? 16'd0 : fih_r) + 16'd1;
          fcnt_r <= fcnt_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // per frame datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mrp_pkg::ST_IDLE: begin
        if (in_take) len_r <= (in_frame_length > LEN_MAX) ? LEN_MAX : in_frame_length;
      end
      mrp_pkg::ST_PREP: begin
        close_r <= close_c;
        whole_r <= need <= room2;
        chunk_r <= psz_frag - mrp_pkg::ENTRY_HDR_BYTES;
        dur_r   <= 32'(dur_prod);
        fnum_r  <= fcnt_r;
        rem_r   <= len_r;
        ncont_r <= 5'd0;
      end
      mrp_pkg::ST_COUNT: begin
        if (!whole_r && rem_big) begin
          rem_r   <= rem_r - chunk_r[11:0];
          ncont_r <= ncont_r + 5'd1;
        end
      end
      mrp_pkg::ST_BOOK: begin
        rem_r <= len_r;
        off_r <= 12'd0;
        epc_r <= pc_r;
        ek_r  <= close_r ? mrp_pkg::EK_CLOSE : mrp_pkg::EK_WHOLE;
      end
      mrp_pkg::ST_EMIT: begin
        if (load) begin
          epc_r <= epc_nxt;
          ek_r  <= ek_nxt;
          if (ek_r == mrp_pkg::EK_FRAG) begin
            rem_r <= rem_r - frag_len;
            off_r <= off_r + frag_len;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec_r <= rec_c;
  end

  mrp_rate_acct u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rate_req),
    .sts   (rate_sts)
  );

  assign out_valid                 = out_valid_r;
  assign out_record_kind           = rec_r.kind;
  assign out_packet_number         = rec_r.pkt;
  assign out_frame_number          = rec_r.frm;
  assign out_data_offset           = rec_r.off;
  assign out_data_length           = rec_r.len;
  assign out_hint_duration         = rec_r.dur;
  assign out_payload_type          = rec_r.pt;
  assign out_peak_bytes_per_second = rec_r.peak;
  assign out_last                  = rec_r.last;

endmodule
